FILE: rtl/gnf_pkg.sv
package gnf_pkg;

  // Table geometry and number formats.
  localparam int TABLE_SIZE     = 256;
  localparam int IDX_W          = $clog2(TABLE_SIZE);
  localparam int MAX_OCTAVES    = 8;
  localparam int FRAC_BITS      = 16;
  localparam logic [31:0] LATTICE_OFFSET = 32'h0000_1000;

  // Command codes as carried in the input tuser.
  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_NOISE1 = 3'd1;
  localparam logic [2:0] CMD_NOISE2 = 3'd2;
  localparam logic [2:0] CMD_NOISE3 = 3'd3;
  localparam logic [2:0] CMD_FBM2   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OCTAVE_COUNT   = 2'd0;
  localparam logic [1:0] CFG_BASE_FREQUENCY = 2'd1;
  localparam logic [1:0] CFG_BASE_AMPLITUDE = 2'd2;

  typedef enum logic [2:0] {
    KIND_LOAD   = 3'd0,
    KIND_NOISE1 = 3'd1,
    KIND_NOISE2 = 3'd2,
    KIND_NOISE3 = 3'd3,
    KIND_FBM2   = 3'd4,
    KIND_NOP    = 3'd5
  } gnf_kind_e;

  typedef struct packed {
    gnf_kind_e          kind;
    logic [7:0]         entry_index;
    logic [7:0]         perm_value;
    logic signed [15:0] grad_one;
    logic signed [15:0] grad_two_x;
    logic signed [15:0] grad_two_y;
    logic signed [15:0] grad_three_x;
    logic signed [15:0] grad_three_y;
    logic signed [15:0] grad_three_z;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } gnf_item_t;

  typedef struct packed {
    logic [3:0]  octave_count;
    logic [23:0] base_frequency;
    logic [23:0] base_amplitude;
  } gnf_cfg_t;

endpackage

FILE: rtl/gradient_noise_fbm_core.sv
// Lattice gradient noise in one, two and three dimensions and a two-dimensional
// fractal sum over octaves, in Q16.16 fixed point. Before any query, the host
// loads the permutation table and the gradient tables with load beats (command 0);
// every load beat writes one entry of all four tables and returns one beat with
// was_load set. A query that touches an entry never loaded returns an undefined
// value. Every input beat produces exactly one output beat, in order. Commands
// 5 to 7 return zero. The front end decodes commands into a two-entry queue, so
// the upstream side keeps moving while the engine works; an output register
// holds a finished result while the engine starts on the next item. The engine
// uses a single shared multiplier and tables with one read port each, so one
// item occupies it until its work is done: a load or an unknown command is
// quickest, then noise1, noise2 and noise3, and the fractal query grows with
// the number of octaves. Configuration registers (octave
// count, base frequency, base amplitude) may be written only while no item is
// in flight.
module gradient_noise_fbm_core import gnf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, low bit up: entry_index[7:0], perm_value[15:8], grad_one[31:16],
  // grad_two_x[47:32], grad_two_y[63:48], grad_three_x[79:64],
  // grad_three_y[95:80], grad_three_z[111:96], coord_x[143:112],
  // coord_y[175:144], coord_z[207:176]
  input  logic [207:0] s_axis_tdata,
  // tuser: cmd[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: noise_value[31:0]
  output logic [31:0]  m_axis_tdata,
  // tuser: was_load[0]
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  gnf_cfg_t  cfg_q, cfg_d;
  logic      q_valid, q_ready;
  gnf_item_t q_item;

  // The configuration port never stalls; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OCTAVE_COUNT:   cfg_d.octave_count   = cfg_data_i[3:0];
        CFG_BASE_FREQUENCY: cfg_d.base_frequency = cfg_data_i;
        CFG_BASE_AMPLITUDE: cfg_d.base_amplitude = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.octave_count   <= 4'd1;
      cfg_q.base_frequency <= 24'h01_0000;
      cfg_q.base_amplitude <= 24'h01_0000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gnf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_ready_i     (q_ready),
    .q_item_o      (q_item)
  );

  gnf_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_item_i      (q_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: rtl/gnf_front.sv
module gnf_front import gnf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [207:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  output logic         q_valid_o,
  input  logic         q_ready_i,
  output gnf_item_t    q_item_o
);

  // Two-entry queue between the decoder and the engine.
  gnf_item_t  fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  gnf_item_t  item;
  logic       push, pop;

  always_comb begin
    case (s_axis_tuser)
      CMD_LOAD:   item.kind = KIND_LOAD;
      CMD_NOISE1: item.kind = KIND_NOISE1;
      CMD_NOISE2: item.kind = KIND_NOISE2;
      CMD_NOISE3: item.kind = KIND_NOISE3;
      CMD_FBM2:   item.kind = KIND_FBM2;
      default:    item.kind = KIND_NOP;
    endcase
    item.entry_index  = s_axis_tdata[7:0];
    item.perm_value   = s_axis_tdata[15:8];
    item.grad_one     = s_axis_tdata[31:16];
    item.grad_two_x   = s_axis_tdata[47:32];
    item.grad_two_y   = s_axis_tdata[63:48];
    item.grad_three_x = s_axis_tdata[79:64];
    item.grad_three_y = s_axis_tdata[95:80];
    item.grad_three_z = s_axis_tdata[111:96];
    item.coord_x      = s_axis_tdata[143:112];
    item.coord_y      = s_axis_tdata[175:144];
    item.coord_z      = s_axis_tdata[207:176];
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign q_valid_o     = (count_q != 2'd0);
  assign q_item_o      = fifo_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

FILE: rtl/gnf_engine.sv
module gnf_engine import gnf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gnf_cfg_t     cfg_i,
  input  logic         q_valid_i,
  output logic         q_ready_o,
  input  gnf_item_t    q_item_i,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,
  output logic [0:0]   m_axis_tuser
);

  typedef enum logic [17:0] {
    ST_IDLE      = 18'h00001,
    ST_FRQ_LO    = 18'h00002,
    ST_FRQ_HI    = 18'h00004,
    ST_FRQ_SUM   = 18'h00008,
    ST_OCT_START = 18'h00010,
    ST_SU_SQ     = 18'h00020,
    ST_SU_S      = 18'h00040,
    ST_SU_ST     = 18'h00080,
    ST_CR_A      = 18'h00100,
    ST_CR_B      = 18'h00200,
    ST_CR_C      = 18'h00400,
    ST_DT_MUL    = 18'h00800,
    ST_DT_ACC    = 18'h01000,
    ST_RD        = 18'h02000,
    ST_RD_ADD    = 18'h04000,
    ST_AMP_MUL   = 18'h08000,
    ST_AMP_ACC   = 18'h10000,
    ST_FIN       = 18'h20000
  } gnf_state_e;

  gnf_state_e state_q, state_d;

  // Lookup tables.
  logic [7:0]  perm_mem [TABLE_SIZE];
  logic [15:0] g1_mem   [TABLE_SIZE];
  logic [31:0] g2_mem   [TABLE_SIZE];
  logic [47:0] g3_mem   [TABLE_SIZE];
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_wa;
  logic             perm_re, grad_re;
  logic [IDX_W-1:0] perm_ra, grad_ra;
  logic [7:0]       perm_rd_q;
  logic [15:0]      g1_q;
  logic [31:0]      g2_q;
  logic [47:0]      g3_q;

  // Working registers.
  logic signed [31:0] coord_q [3];
  logic signed [31:0] coord_d [3];
  logic [15:0]        frac_q [3];
  logic [15:0]        frac_d [3];
  logic [IDX_W-1:0]   b0_q [3];
  logic [IDX_W-1:0]   b0_d [3];
  logic [16:0]        s_q [3];
  logic [16:0]        s_d [3];
  logic signed [31:0] lv_q [3];
  logic signed [31:0] lv_d [3];
  logic [1:0]         dim_q, dim_d;
  logic               fbm_q, fbm_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [2:0]         corner_q, corner_d;
  logic signed [57:0] acc_q, acc_d;
  logic signed [57:0] prod_q;
  logic signed [31:0] val_q, val_d;
  logic signed [39:0] sum_q, sum_d;
  logic signed [39:0] res_q, res_d;
  logic               load_q, load_d;
  logic [23:0]        amp_q, amp_d;
  logic [3:0]         oct_q, oct_d, octn_q, octn_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        out_data_q, out_data_d;
  logic               out_load_q, out_load_d;

  // Shared multiplier, result registered.
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod_d;

  logic [3:0]         corner_ext;
  logic [15:0]        frac_cur;
  logic [17:0]        r_cur;
  logic signed [15:0] g_cur;
  logic signed [31:0] diff;
  logic signed [57:0] tmp;
  logic [17:0]        fade_fac;

  assign corner_ext = {1'b0, corner_q};
  assign prod_d     = mul_a * mul_b;

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sh00_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -40'sh00_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    state_d     = state_q;
    coord_d     = coord_q;
    frac_d      = frac_q;
    b0_d        = b0_q;
    s_d         = s_q;
    lv_d        = lv_q;
    dim_d       = dim_q;
    fbm_d       = fbm_q;
    cnt_d       = cnt_q;
    corner_d    = corner_q;
    acc_d       = acc_q;
    val_d       = val_q;
    sum_d       = sum_q;
    res_d       = res_q;
    load_d      = load_q;
    amp_d       = amp_q;
    oct_d       = oct_q;
    octn_d      = octn_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_load_d  = out_load_q;
    q_ready_o   = 1'b0;
    tbl_we      = 1'b0;
    tbl_wa      = q_item_i.entry_index[IDX_W-1:0];
    perm_re     = 1'b0;
    perm_ra     = '0;
    grad_re     = 1'b0;
    grad_ra     = '0;
    mul_a       = '0;
    mul_b       = '0;
    frac_cur    = coord_q[cnt_q][FRAC_BITS-1:0];
    r_cur       = {2'b00, frac_q[cnt_q]} - (corner_ext[cnt_q] ? 18'h10000 : 18'h00000);
    fade_fac    = 18'h30000 - {1'b0, frac_cur, 1'b0};
    diff        = val_q - lv_q[cnt_q];
    tmp         = acc_q + prod_q;
    case (dim_q)
      2'd1:    g_cur = g1_q;
      2'd2:    g_cur = g2_q[16*cnt_q +: 16];
      default: g_cur = g3_q[16*cnt_q +: 16];
    endcase

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_ready_o  = 1'b1;
          coord_d[0] = q_item_i.coord_x;
          coord_d[1] = q_item_i.coord_y;
          coord_d[2] = q_item_i.coord_z;
          cnt_d      = 2'd0;
          fbm_d      = 1'b0;
          load_d     = 1'b0;
          res_d      = '0;
          case (q_item_i.kind)
            KIND_LOAD: begin
              tbl_we  = 1'b1;
              load_d  = 1'b1;
              state_d = ST_FIN;
            end
            KIND_NOISE1: begin
              dim_d   = 2'd1;
              state_d = ST_SU_SQ;
            end
            KIND_NOISE2: begin
              dim_d   = 2'd2;
              state_d = ST_SU_SQ;
            end
            KIND_NOISE3: begin
              dim_d   = 2'd3;
              state_d = ST_SU_SQ;
            end
            KIND_FBM2: begin
              dim_d   = 2'd2;
              fbm_d   = 1'b1;
              sum_d   = '0;
              oct_d   = '0;
              amp_d   = cfg_i.base_amplitude;
              octn_d  = (cfg_i.octave_count > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES)
                                                               : cfg_i.octave_count;
              state_d = ST_FRQ_LO;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_FRQ_LO: begin
        mul_a   = {coord_q[cnt_q][31], coord_q[cnt_q]};
        mul_b   = $signed({13'b0, cfg_i.base_frequency[11:0]});
        state_d = ST_FRQ_HI;
      end
      ST_FRQ_HI: begin
        acc_d   = prod_q;
        mul_a   = {coord_q[cnt_q][31], coord_q[cnt_q]};
        mul_b   = $signed({13'b0, cfg_i.base_frequency[23:12]});
        state_d = ST_FRQ_SUM;
      end
      ST_FRQ_SUM: begin
        tmp            = acc_q + (prod_q <<< 12);
        coord_d[cnt_q] = tmp[47:16];
        if (cnt_q == 2'd1) begin
          cnt_d   = 2'd0;
          state_d = ST_OCT_START;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = ST_FRQ_LO;
        end
      end
      ST_OCT_START: begin
        cnt_d = 2'd0;
        if (oct_q == octn_q) begin
          res_d   = sum_q;
          state_d = ST_FIN;
        end else begin
          state_d = ST_SU_SQ;
        end
      end
      ST_SU_SQ: begin
        mul_a   = $signed({17'b0, frac_cur});
        mul_b   = $signed({9'b0, frac_cur});
        state_d = ST_SU_S;
      end
      ST_SU_S: begin
        mul_a   = $signed({17'b0, prod_q[31:16]});
        mul_b   = $signed({7'b0, fade_fac});
        state_d = ST_SU_ST;
      end
      ST_SU_ST: begin
        frac_d[cnt_q] = frac_cur;
        b0_d[cnt_q]   = coord_q[cnt_q][FRAC_BITS +: IDX_W] + LATTICE_OFFSET[IDX_W-1:0];
        s_d[cnt_q]    = prod_q[32:16];
        if (cnt_q == dim_q - 2'd1) begin
          corner_d = 3'd0;
          state_d  = ST_CR_A;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = ST_SU_SQ;
        end
      end
      ST_CR_A: begin
        perm_re = 1'b1;
        perm_ra = b0_q[0] + IDX_W'(corner_q[0]);
        state_d = ST_CR_B;
      end
      ST_CR_B: begin
        acc_d = '0;
        cnt_d = 2'd0;
        if (dim_q == 2'd1) begin
          grad_re = 1'b1;
          grad_ra = perm_rd_q[IDX_W-1:0];
          state_d = ST_DT_MUL;
        end else begin
          perm_re = 1'b1;
          perm_ra = perm_rd_q[IDX_W-1:0] + b0_q[1] + IDX_W'(corner_q[1]);
          state_d = ST_CR_C;
        end
      end
      ST_CR_C: begin
        grad_re = 1'b1;
        if (dim_q == 2'd3) begin
          grad_ra = perm_rd_q[IDX_W-1:0] + b0_q[2] + IDX_W'(corner_q[2]);
        end else begin
          grad_ra = perm_rd_q[IDX_W-1:0];
        end
        state_d = ST_DT_MUL;
      end
      ST_DT_MUL: begin
        mul_a   = {{15{r_cur[17]}}, r_cur};
        mul_b   = {{9{g_cur[15]}}, g_cur};
        state_d = ST_DT_ACC;
      end
      ST_DT_ACC: begin
        acc_d = tmp;
        if (cnt_q == dim_q - 2'd1) begin
          val_d   = tmp[46:15];
          cnt_d   = 2'd0;
          state_d = ST_RD;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = ST_DT_MUL;
        end
      end
      ST_RD: begin
        if (cnt_q == dim_q) begin
          if (fbm_q) begin
            state_d = ST_AMP_MUL;
          end else begin
            res_d   = {{8{val_q[31]}}, val_q};
            state_d = ST_FIN;
          end
        end else if (!corner_ext[cnt_q]) begin
          // Left corner of this level: park it until its right partner arrives.
          lv_d[cnt_q] = val_q;
          corner_d    = corner_q + 3'd1;
          state_d     = ST_CR_A;
        end else begin
          mul_a   = {diff[31], diff};
          mul_b   = $signed({8'b0, s_q[cnt_q]});
          state_d = ST_RD_ADD;
        end
      end
      ST_RD_ADD: begin
        val_d   = lv_q[cnt_q] + prod_q[47:16];
        cnt_d   = cnt_q + 2'd1;
        state_d = ST_RD;
      end
      ST_AMP_MUL: begin
        mul_a   = {val_q[31], val_q};
        mul_b   = $signed({1'b0, amp_q});
        state_d = ST_AMP_ACC;
      end
      ST_AMP_ACC: begin
        sum_d      = sum_q + prod_q[55:16];
        coord_d[0] = {coord_q[0][30:0], 1'b0};
        coord_d[1] = {coord_q[1][30:0], 1'b0};
        amp_d      = {1'b0, amp_q[23:1]};
        oct_d      = oct_q + 4'd1;
        state_d    = ST_OCT_START;
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = sat32(res_q);
          out_load_d  = load_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_load_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q    <= coord_d;
    frac_q     <= frac_d;
    b0_q       <= b0_d;
    s_q        <= s_d;
    lv_q       <= lv_d;
    dim_q      <= dim_d;
    fbm_q      <= fbm_d;
    cnt_q      <= cnt_d;
    corner_q   <= corner_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    val_q      <= val_d;
    sum_q      <= sum_d;
    res_q      <= res_d;
    load_q     <= load_d;
    amp_q      <= amp_d;
    oct_q      <= oct_d;
    octn_q     <= octn_d;
    out_data_q <= out_data_d;
    out_load_q <= out_load_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      perm_mem[tbl_wa] <= q_item_i.perm_value;
    end
    if (perm_re) begin
      perm_rd_q <= perm_mem[perm_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      g1_mem[tbl_wa] <= q_item_i.grad_one;
      g2_mem[tbl_wa] <= {q_item_i.grad_two_y, q_item_i.grad_two_x};
      g3_mem[tbl_wa] <= {q_item_i.grad_three_z, q_item_i.grad_three_y,
                         q_item_i.grad_three_x};
    end
    if (grad_re) begin
      g1_q <= g1_mem[grad_ra];
      g2_q <= g2_mem[grad_ra];
      g3_q <= g3_mem[grad_ra];
    end
  end

endmodule
